// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked, also checked during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rkm_pkg.sv -----
package rkm_pkg;

    localparam int HASH_W = 40;
    localparam logic [HASH_W-1:0] HASH_MOD = 40'd999999000001;
    localparam logic [7:0] CHAR_BIAS = 8'd31;

    localparam int MUL_BIT_W = 6;
    localparam logic [MUL_BIT_W-1:0] MUL_LAST = 6'd39;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    typedef enum logic {
        OP_DBLADD,
        OP_SUB
    } t_op;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
    } t_out_item;

    // byte minus bias, taken modulo the hash modulus
    function automatic logic [HASH_W-1:0] sym_value(input logic [7:0] b);
        logic [7:0] d;
        d = b - CHAR_BIAS;
        if (b >= CHAR_BIAS) begin
            return {32'd0, d};
        end else begin
            return HASH_MOD - {32'd0, CHAR_BIAS - b};
        end
    endfunction

endpackage

// ----- hw/rtl/rkm_chan_if.sv -----
interface rkm_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/rkm_mod_unit.sv -----
module rkm_mod_unit (
    input  rkm_pkg::t_op                 i_op,
    input  logic [rkm_pkg::HASH_W-1:0]   i_a,
    input  logic [rkm_pkg::HASH_W-1:0]   i_b,
    output logic [rkm_pkg::HASH_W-1:0]   o_y
);
    localparam int HW = rkm_pkg::HASH_W;
    localparam logic [HW+1:0] MOD_X1 = {2'b00, rkm_pkg::HASH_MOD};
    localparam logic [HW+1:0] MOD_X2 = {1'b0, rkm_pkg::HASH_MOD, 1'b0};

    logic [HW+1:0] sum;
    logic [HW+1:0] sum_m1;
    logic [HW+1:0] sum_m2;
    logic [HW:0]   diff;
    logic [HW-1:0] diff_fix;

    // (2a + b) mod M and (a - b) mod M, operands already reduced
    always_comb begin
        sum      = {1'b0, i_a, 1'b0} + {2'b00, i_b};
        sum_m1   = sum - MOD_X1;
        sum_m2   = sum - MOD_X2;
        diff     = {1'b0, i_a} - {1'b0, i_b};
        diff_fix = diff[HW-1:0] + rkm_pkg::HASH_MOD;
        case (i_op)
            rkm_pkg::OP_DBLADD: begin
                if (sum >= MOD_X2) begin
                    o_y = sum_m2[HW-1:0];
                end else if (sum >= MOD_X1) begin
                    o_y = sum_m1[HW-1:0];
                end else begin
                    o_y = sum[HW-1:0];
                end
            end
            rkm_pkg::OP_SUB: begin
                if (diff[HW]) begin
                    o_y = diff_fix;
                end else begin
                    o_y = diff[HW-1:0];
                end
            end
            default: begin
                o_y = '0;
            end
        endcase
    end
endmodule

// ----- hw/rtl/rabin_karp_stream_matcher_top.sv -----
// Streaming Rabin-Karp string matcher.
// Input channel i_in carries items {cmd, data_byte, last}: cmd 0 loads a
// pattern byte, cmd 1 feeds a text byte; last closes the pattern or the text.
// Output channel o_out carries {found, position}: at most one item per text,
// the 1-based start of the first match, or found 0 / position 0 on the last
// text byte when nothing matched.
// One item at a time: i_in.ready is high only while the sequencer is idle.
// Pattern byte: S_PHASH, then S_PPOW; only S_PHASH once PATTERN_MAX bytes
// are held. Text byte after a match or past TEXT_MAX: no hash step.
// Text byte while the window is filling: S_ADD, then S_CHK. Text byte with a
// full window: S_OLD, the 40-step bit-serial modular multiply (S_MUL) of the
// outgoing byte by the high power on the one shared mod-add/subtract unit, then
// S_SUB, S_ADD, S_CHK. A hash hit adds S_CMP_A and S_CMP_B per compared byte
// (one registered read of each byte store per byte). A decided result goes to
// a pending register, then S_EMIT moves it to the output register; if o_out stalls
// with an item held, the sequencer waits, taking no input until the register frees.
// Reset (synchronous, active low) empties the pattern, clears the window
// hash and counters, and drops any held result; no clearing pass is needed.
`include "assert_macros.svh"

module rabin_karp_stream_matcher_top #(
    parameter int              PATTERN_MAX = 64,
    parameter longint unsigned TEXT_MAX    = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rkm_chan_if.sink           i_in,
    rkm_chan_if.source         o_out
);
    localparam int HW    = rkm_pkg::HASH_W;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CNT_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX + 1) : 1;
    localparam int CW    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int PW    = (CW > 16) ? CW : 16;
    localparam int BW    = rkm_pkg::MUL_BIT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASH,
        S_PPOW,
        S_OLD,
        S_MUL,
        S_SUB,
        S_ADD,
        S_CHK,
        S_CMP_A,
        S_CMP_B,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [7:0]       pattern_mem [PATTERN_MAX];
    logic [7:0]       window_mem  [PATTERN_MAX];
    logic [7:0]       r_w_rdata;
    logic [7:0]       r_p_rdata;

    logic [LEN_W-1:0] r_plen;
    logic [HW-1:0]    r_ph;
    logic [HW-1:0]    r_hp;
    logic [HW-1:0]    r_wh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             r_closed;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_k;
    logic [7:0]       r_byte;
    logic             r_fin;
    logic [HW-1:0]    r_old;
    logic [HW-1:0]    r_acc;
    logic [BW-1:0]    r_bit;
    logic             r_pend_found;
    logic [15:0]      r_pend_pos;
    logic             r_out_valid;
    logic             r_out_found;
    logic [15:0]      r_out_pos;

    logic             in_acc;
    logic             text_sat;
    logic             full_win;
    logic             plen_room;
    logic             k_last;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] n_ptr;
    logic [IDX_W-1:0] w_raddr;
    logic [PW-1:0]    pos_calc;
    logic [HW-1:0]    byte_sym;

    rkm_pkg::t_op     unit_op;
    logic [HW-1:0]    unit_a;
    logic [HW-1:0]    unit_b;
    logic [HW-1:0]    unit_y;

    assign i_in.ready            = (r_state == S_IDLE);
    assign in_acc                = i_in.valid && i_in.ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.payload.found    = r_out_found;
    assign o_out.payload.position = r_out_pos;

    assign text_sat  = (r_cnt >= CNT_W'(TEXT_MAX));
    assign full_win  = (CW'(r_cnt) >= CW'(r_plen));
    assign plen_room = (r_plen < LEN_W'(PATTERN_MAX));
    assign k_last    = ((LEN_W'(r_k) + LEN_W'(1)) == r_plen);
    assign n_idx     = ((LEN_W'(r_idx) + LEN_W'(1)) == r_plen) ? '0 : r_idx + IDX_W'(1);
    assign n_ptr     = ((LEN_W'(r_ptr) + LEN_W'(1)) == r_plen) ? '0 : r_ptr + IDX_W'(1);
    assign w_raddr   = (r_state == S_CMP_A) ? r_ptr : r_idx;
    assign pos_calc  = PW'(r_cnt) - PW'(r_plen) + PW'(1);
    assign byte_sym  = rkm_pkg::sym_value(r_byte);

    always_comb begin
        unit_op = rkm_pkg::OP_DBLADD;
        unit_a  = '0;
        unit_b  = '0;
        case (r_state)
            S_PHASH: begin
                unit_a = r_ph;
                unit_b = byte_sym;
            end
            S_PPOW: begin
                unit_a = r_hp;
            end
            S_MUL: begin
                unit_a = r_acc;
                unit_b = r_hp[r_bit] ? r_old : '0;
            end
            S_SUB: begin
                unit_op = rkm_pkg::OP_SUB;
                unit_a  = r_wh;
                unit_b  = r_acc;
            end
            S_ADD: begin
                unit_a = r_wh;
                unit_b = byte_sym;
            end
            default: begin
                unit_a = '0;
            end
        endcase
    end

    rkm_mod_unit u_mod (
        .i_op (unit_op),
        .i_a  (unit_a),
        .i_b  (unit_b),
        .o_y  (unit_y)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_PHASH && plen_room) begin
            pattern_mem[r_plen[IDX_W-1:0]] <= r_byte;
        end
        r_p_rdata <= pattern_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            window_mem[r_idx] <= r_byte;
        end
        r_w_rdata <= window_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_plen      <= '0;
            r_ph        <= '0;
            r_hp        <= HW'(1);
            r_wh        <= '0;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_closed    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_byte <= i_in.payload.data_byte;
                        r_fin  <= i_in.payload.last;
                        if (i_in.payload.cmd == rkm_pkg::CMD_PATTERN) begin
                            r_closed <= i_in.payload.last;
                            if (r_closed) begin
                                r_plen <= '0;
                                r_ph   <= '0;
                                r_hp   <= HW'(1);
                                r_cnt  <= '0;
                                r_wh   <= '0;
                                r_done <= 1'b0;
                                r_idx  <= '0;
                            end
                            r_state <= S_PHASH;
                        end else begin
                            r_closed <= 1'b1;
                            if (r_done || text_sat) begin
                                if (i_in.payload.last) begin
                                    r_cnt  <= '0;
                                    r_wh   <= '0;
                                    r_done <= 1'b0;
                                    r_idx  <= '0;
                                    if (!r_done) begin
                                        r_pend_found <= 1'b0;
                                        r_pend_pos   <= '0;
                                        r_state      <= S_EMIT;
                                    end
                                end
                            end else if (r_plen == '0) begin
                                // empty pattern matches at once
                                if (i_in.payload.last) begin
                                    r_cnt  <= '0;
                                    r_wh   <= '0;
                                    r_idx  <= '0;
                                end else begin
                                    r_done <= 1'b1;
                                end
                                r_pend_found <= 1'b1;
                                r_pend_pos   <= 16'd1;
                                r_state      <= S_EMIT;
                            end else if (full_win) begin
                                r_state <= S_OLD;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end
                    end
                end
                S_PHASH: begin
                    if (plen_room) begin
                        r_ph    <= unit_y;
                        r_state <= S_PPOW;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PPOW: begin
                    if (r_plen != '0) begin
                        r_hp <= unit_y;
                    end
                    r_plen  <= r_plen + LEN_W'(1);
                    r_state <= S_IDLE;
                end
                S_OLD: begin
                    r_old   <= rkm_pkg::sym_value(r_w_rdata);
                    r_acc   <= '0;
                    r_bit   <= rkm_pkg::MUL_LAST;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= unit_y;
                    if (r_bit == '0) begin
                        r_state <= S_SUB;
                    end else begin
                        r_bit <= r_bit - BW'(1);
                    end
                end
                S_SUB: begin
                    r_wh    <= unit_y;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_wh    <= unit_y;
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_idx   <= n_idx;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (full_win && r_wh == r_ph) begin
                        r_k     <= '0;
                        r_ptr   <= r_idx;
                        r_state <= S_CMP_A;
                    end else if (r_fin) begin
                        r_cnt        <= '0;
                        r_wh         <= '0;
                        r_done       <= 1'b0;
                        r_idx        <= '0;
                        r_pend_found <= 1'b0;
                        r_pend_pos   <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CMP_A: begin
                    r_state <= S_CMP_B;
                end
                S_CMP_B: begin
                    if (r_w_rdata != r_p_rdata) begin
                        if (r_fin) begin
                            r_cnt        <= '0;
                            r_wh         <= '0;
                            r_done       <= 1'b0;
                            r_idx        <= '0;
                            r_pend_found <= 1'b0;
                            r_pend_pos   <= '0;
                            r_state      <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (k_last) begin
                        r_pend_found <= 1'b1;
                        r_pend_pos   <= pos_calc[15:0];
                        if (r_fin) begin
                            r_cnt <= '0;
                            r_wh  <= '0;
                            r_idx <= '0;
                        end else begin
                            r_done <= 1'b1;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_ptr   <= n_ptr;
                        r_state <= S_CMP_A;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_pend_found;
                        r_out_pos   <= r_pend_pos;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CLK(a_wh_reduced, r_wh < rkm_pkg::HASH_MOD, "window hash not reduced")
    `ASSERT_CLK(a_pat_reduced, (r_ph < rkm_pkg::HASH_MOD) && (r_hp < rkm_pkg::HASH_MOD), "pattern hash or power not reduced")
    `ASSERT_CLK(a_mul_count, (r_state == S_MUL && r_bit != '0) |=> (r_state == S_MUL && r_bit == $past(r_bit) - BW'(1)), "multiply step skipped")
    `ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out.valid, "result valid after reset")

endmodule

// ----- verif/tb_rabin_karp_stream_matcher_top.sv -----
`timescale 1ns / 1ps

class rkm_match_scoreboard #(int TEXT_LIMIT = 65535);

    localparam int PAT_MAX = 64;
    localparam logic [39:0] MODULUS = 40'd999999000001;

    logic [7:0]  pat_mem [PAT_MAX];
    logic [7:0]  win_mem [PAT_MAX];
    int          pat_len;
    logic [39:0] pat_hash;
    logic [39:0] top_power;
    logic [39:0] win_hash;
    int          text_pos;
    bit          matched_flag;
    bit          pat_sealed;

    rkm_pkg::t_out_item pending_results [$];
    int          mismatches;
    int          results_checked;
    int          match_count;
    int          miss_count;
    int          false_hits;

    function new();
        pat_len = 0;
        pat_hash = '0;
        top_power = 40'd1;
        pat_sealed = 0;
        end_text();
    endfunction

    function void end_text();
        text_pos = 0;
        win_hash = '0;
        matched_flag = 0;
    endfunction

    function logic [39:0] add_m(logic [39:0] a, logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[39:0];
    endfunction

    function logic [39:0] mul_m(logic [39:0] a, logic [39:0] b);
        logic [79:0] p;
        p = {40'd0, a} * {40'd0, b};
        p = p % {40'd0, MODULUS};
        return p[39:0];
    endfunction

    // byte value less the character bias, wrapped into the field
    function logic [39:0] sym_of(logic [7:0] b);
        return add_m({32'd0, b}, MODULUS - 40'd31);
    endfunction

    function void expect_result(logic found, logic [15:0] pos);
        rkm_pkg::t_out_item e;
        e.found = found;
        e.position = pos;
        pending_results.push_back(e);
        if (found) begin
            match_count++;
        end else begin
            miss_count++;
        end
    endfunction

    // returns 1 when the item does real work in the block
    function bit take_item(rkm_pkg::t_in_item it);
        int  slot;
        bit  same;
        bit  stored;
        stored = 0;
        if (it.cmd == rkm_pkg::CMD_PATTERN) begin
            if (pat_sealed) begin
                pat_len = 0;
                pat_hash = '0;
                top_power = 40'd1;
                pat_sealed = 0;
                end_text();
            end
            if (pat_len < PAT_MAX) begin
                pat_mem[pat_len] = it.data_byte;
                pat_hash = add_m(add_m(pat_hash, pat_hash), sym_of(it.data_byte));
                if (pat_len > 0) begin
                    top_power = add_m(top_power, top_power);
                end
                pat_len++;
                stored = 1;
            end
            if (it.last) begin
                pat_sealed = 1;
            end
            return stored || it.last;
        end

        pat_sealed = 1;
        if (matched_flag || text_pos >= TEXT_LIMIT) begin
            if (it.last) begin
                if (!matched_flag) begin
                    expect_result(1'b0, 16'd0);
                end
                end_text();
            end
            return it.last;
        end

        if (pat_len == 0) begin
            if (it.last) begin
                end_text();
            end else begin
                matched_flag = 1;
            end
            expect_result(1'b1, 16'd1);
            return 1;
        end

        slot = text_pos % pat_len;
        if (text_pos >= pat_len) begin
            win_hash = add_m(win_hash, MODULUS - mul_m(sym_of(win_mem[slot]), top_power));
        end
        win_hash = add_m(add_m(win_hash, win_hash), sym_of(it.data_byte));
        win_mem[slot] = it.data_byte;
        text_pos++;

        if (text_pos >= pat_len && win_hash == pat_hash) begin
            same = 1;
            for (int k = 0; k < pat_len; k++) begin
                if (win_mem[(slot + 1 + k) % pat_len] != pat_mem[k]) begin
                    same = 0;
                end
            end
            if (same) begin
                expect_result(1'b1, 16'(text_pos - pat_len + 1));
                if (it.last) begin
                    end_text();
                end else begin
                    matched_flag = 1;
                end
                return 1;
            end
            false_hits++;
        end

        if (it.last) begin
            end_text();
            expect_result(1'b0, 16'd0);
        end
        return 1;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function void check_result(rkm_pkg::t_out_item got);
        rkm_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            flag($sformatf("unexpected result found=%0d position=%0d",
                           got.found, got.position));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.found !== want.found || got.position !== want.position) begin
            flag($sformatf("expected found=%0d position=%0d, got found=%0d position=%0d",
                           want.found, want.position, got.found, got.position));
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

endclass

module tb_rabin_karp_stream_matcher_top;

    // short text limit so that overlong texts are reachable
    localparam int TEXT_LIMIT   = 96;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASE_ITEMS  = 190;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rkm_chan_if #(.t_payload(rkm_pkg::t_in_item))  in_if ();
    rkm_chan_if #(.t_payload(rkm_pkg::t_out_item)) out_if ();

    rabin_karp_stream_matcher_top #(
        .TEXT_MAX(TEXT_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rkm_match_scoreboard #(TEXT_LIMIT) sb;

    int          tx_idle_pct;
    int          rx_stall_pct;
    int          hold_req;
    int          hold_left;
    int          useful_items;
    int          items_sent;
    int          input_stalls;
    int          cycle_count;
    logic [7:0]  alph [3];
    logic [7:0]  cur_pat [$];
    bit          have_pat;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.payload);
            end
            if (in_if.valid && !in_if.ready) begin
                input_stalls++;
            end
        end
    end

    // result side: random stalls plus a single long hold-off at the start of the first random phase
    initial begin
        out_if.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic drive_item(input logic cmd, input logic [7:0] b, input logic fin);
        rkm_pkg::t_in_item it;
        it.cmd = cmd;
        it.data_byte = b;
        it.last = fin;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        if (sb.take_item(it)) begin
            useful_items++;
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 12) begin
            return 8'($urandom_range(255));
        end
        return alph[$urandom_range(2)];
    endfunction

    task automatic random_round();
        int          r;
        int          n;
        int          tl;
        int          emb;
        int          off;
        logic [7:0]  b;
        logic [7:0]  text_buf [$];
        r = $urandom_range(99);
        if (r < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                drive_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
            end
            return;
        end

        if (!have_pat || $urandom_range(99) < 35) begin
            for (int i = 0; i < 3; i++) begin
                alph[i] = 8'($urandom_range(255));
            end
            n = ($urandom_range(99) < 3) ? $urandom_range(65, 68) : $urandom_range(1, 6);
            cur_pat.delete();
            for (int i = 0; i < n; i++) begin
                b = pick_byte();
                cur_pat.push_back(b);
                drive_item(rkm_pkg::CMD_PATTERN, b,
                           (i == n - 1) && ($urandom_range(99) >= 10));
            end
            have_pat = 1;
        end

        // unterminated text, cut off by whatever comes next
        if (r < 16) begin
            n = $urandom_range(1, 5);
            repeat (n) begin
                drive_item(rkm_pkg::CMD_TEXT, pick_byte(), 1'b0);
            end
            return;
        end

        repeat ($urandom_range(1, 3)) begin
            tl = ($urandom_range(99) < 3) ? $urandom_range(97, 104) : $urandom_range(1, 20);
            text_buf.delete();
            repeat (tl) begin
                text_buf.push_back(pick_byte());
            end
            if ($urandom_range(99) < 50) begin
                emb = (cur_pat.size() > 64) ? 64 : cur_pat.size();
                while (text_buf.size() < emb) begin
                    text_buf.push_back(pick_byte());
                end
                off = $urandom_range(text_buf.size() - emb);
                for (int k = 0; k < emb; k++) begin
                    text_buf[off + k] = cur_pat[k];
                end
            end
            for (int k = 0; k < text_buf.size(); k++) begin
                drive_item(rkm_pkg::CMD_TEXT, text_buf[k], k == text_buf.size() - 1);
            end
        end
    endtask

    initial begin
        int tx_plan [4];
        int rx_plan [4];
        int goal;
        tx_plan = '{0, 59, 0, 22};
        rx_plan = '{0, 0, 59, 22};
        sb = new();
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 0;
        have_pat = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern right after reset: every text matches at 1
        drive_item(rkm_pkg::CMD_TEXT, 8'h00, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'hFF, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'h41, 1'b1);
        drive_item(rkm_pkg::CMD_TEXT, 8'h7F, 1'b1);
        // extreme bytes, match decided on the last text item
        drive_item(rkm_pkg::CMD_PATTERN, 8'hFF, 1'b0);
        drive_item(rkm_pkg::CMD_PATTERN, 8'h00, 1'b1);
        drive_item(rkm_pkg::CMD_TEXT, 8'h00, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'hFF, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'h00, 1'b1);
        // text closes an open pattern
        drive_item(rkm_pkg::CMD_PATTERN, 8'h61, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'h61, 1'b1);
        // equal hashes, different bytes, then a real match
        drive_item(rkm_pkg::CMD_PATTERN, 8'd40, 1'b0);
        drive_item(rkm_pkg::CMD_PATTERN, 8'd40, 1'b1);
        drive_item(rkm_pkg::CMD_TEXT, 8'd41, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd38, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd40, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd40, 1'b1);
        // text shorter than pattern, then bytes after a match
        drive_item(rkm_pkg::CMD_PATTERN, 8'd1, 1'b0);
        drive_item(rkm_pkg::CMD_PATTERN, 8'd2, 1'b0);
        drive_item(rkm_pkg::CMD_PATTERN, 8'd3, 1'b1);
        drive_item(rkm_pkg::CMD_TEXT, 8'd1, 1'b1);
        drive_item(rkm_pkg::CMD_TEXT, 8'd1, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd2, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd3, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd4, 1'b0);
        drive_item(rkm_pkg::CMD_TEXT, 8'd5, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = tx_plan[ph];
            rx_stall_pct = rx_plan[ph];
            if (ph == 0) begin
                hold_req = HOLD_CYCLES;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                random_round();
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        rx_stall_pct = 0;
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);

        $display("sent %0d items (%0d effective) over four idle/stall mixes", items_sent,
                 useful_items);
        $display("results %0d: %0d matches, %0d not found, %0d hash hits rejected, %0d input stalls",
                 sb.results_checked, sb.match_count, sb.miss_count, sb.false_hits,
                 input_stalls);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
